@@ rtl/cbmc_pkg.sv @@
// ----------------------------------------------------------------------------
// cbmc_pkg
// Shared types and constants of the bilinear chroma motion compensation block.
// ----------------------------------------------------------------------------
package cbmc_pkg;

	localparam int PIX_W      = 8;
	localparam int FRAC_W     = 3;
	localparam int BW_W       = 4;
	localparam int BH_W       = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_FRAC_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAC_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = 3'd4;

	localparam logic [BW_W-1:0] BLOCK_WIDTH_RST  = 4'd8;
	localparam logic [BH_W-1:0] BLOCK_HEIGHT_RST = 5'd8;

	localparam int FRAC_ONE  = 8;
	localparam int ROUND     = 32;
	localparam int SHIFT     = 6;
	localparam int PIX_MAX   = 255;
	localparam int WEIGHT_W  = 7;
	localparam int PROD_W    = PIX_W + WEIGHT_W;
	localparam int SUM_W     = PROD_W + 2;

	typedef struct packed {
		logic [PIX_W-1:0] tl;
		logic [PIX_W-1:0] tr;
		logic [PIX_W-1:0] bl;
		logic [PIX_W-1:0] br;
		logic [PIX_W-1:0] dst;
		logic             last;
	} cbmc_taps_t;

endpackage

@@ rtl/cbmc_ram.sv @@
// ----------------------------------------------------------------------------
// cbmc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cbmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/cbmc_filter.sv @@
// ----------------------------------------------------------------------------
// cbmc_filter
// Weighted 2x2 sum, rounding, clamp and optional average with the destination.
// ----------------------------------------------------------------------------
module cbmc_filter
	import cbmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [FRAC_W-1:0] frac_x,
	input  logic [FRAC_W-1:0] frac_y,
	input  logic              average_mode,
	input  logic              in_valid,
	output logic              in_ready,
	input  cbmc_taps_t        taps,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  out_pixel,
	output logic              out_last
);

	logic [FRAC_W:0]   ix, iy, fx, fy;
	logic [WEIGHT_W-1:0] wa, wb, wc, wd;
	logic [PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic [PIX_W-1:0]  dst_s2;
	logic              last_s2;
	logic              valid_s2;
	logic              out_valid_q;
	logic              out_free, s2_free;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-SHIFT-1:0] shifted;
	logic [PIX_W-1:0]  clamped;
	logic [PIX_W:0]    avg;
	logic [PIX_W-1:0]  result;

	assign fx = {1'b0, frac_x};
	assign fy = {1'b0, frac_y};
	assign ix = (FRAC_W+1)'(FRAC_ONE) - fx;
	assign iy = (FRAC_W+1)'(FRAC_ONE) - fy;
	assign wa = WEIGHT_W'({3'b0, ix} * {3'b0, iy});
	assign wb = WEIGHT_W'({3'b0, fx} * {3'b0, iy});
	assign wc = WEIGHT_W'({3'b0, ix} * {3'b0, fy});
	assign wd = WEIGHT_W'({3'b0, fx} * {3'b0, fy});

	assign out_free = !out_valid_q || out_ready;
	assign s2_free  = !valid_s2 || out_free;
	assign in_ready = s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && in_valid) begin
			pa_s2   <= PROD_W'({{WEIGHT_W{1'b0}}, taps.tl} * {{PIX_W{1'b0}}, wa});
			pb_s2   <= PROD_W'({{WEIGHT_W{1'b0}}, taps.tr} * {{PIX_W{1'b0}}, wb});
			pc_s2   <= PROD_W'({{WEIGHT_W{1'b0}}, taps.bl} * {{PIX_W{1'b0}}, wc});
			pd_s2   <= PROD_W'({{WEIGHT_W{1'b0}}, taps.br} * {{PIX_W{1'b0}}, wd});
			dst_s2  <= taps.dst;
			last_s2 <= taps.last;
		end
	end

	always_comb begin
		sum     = SUM_W'(pa_s2) + SUM_W'(pb_s2) + SUM_W'(pc_s2) + SUM_W'(pd_s2)
		          + SUM_W'(ROUND);
		shifted = sum[SUM_W-1:SHIFT];
		clamped = (shifted > (SUM_W-SHIFT)'(PIX_MAX)) ? PIX_W'(PIX_MAX)
		                                              : shifted[PIX_W-1:0];
		avg     = ({1'b0, clamped} + {1'b0, dst_s2} + (PIX_W+1)'(1)) >> 1;
		result  = average_mode ? avg[PIX_W-1:0] : clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			out_pixel <= result;
			out_last  <= last_s2;
		end
	end

	assign out_valid = out_valid_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s2_free |=> valid_s2 && $stable(pa_s2) && $stable(dst_s2))
		else $error("filter stage lost a held word");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && valid_s2 |=> valid_s2)
		else $error("stage two dropped while output stalled");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> shifted <= (SUM_W-SHIFT)'(PIX_MAX))
		else $error("weighted sum out of pixel range");

endmodule

@@ rtl/chroma_bilinear_mc.sv @@
// ----------------------------------------------------------------------------
// chroma_bilinear_mc
// Eighth-pel bilinear chroma motion compensation over a streamed source window.
// ----------------------------------------------------------------------------
// Takes one source word per cycle when not stalled, block_height+1 rows of
// block_width+1 pixels in raster order, and returns one pixel for every source
// word outside the first row and column. The previous row sits in a one-read
// one-write RAM of MAX_WIDTH+1 entries: each word reads the entry above-right,
// reuses the previous read for above-left, and writes one entry; the
// end-of-row pixel is written in the next word's cycle, so the single write
// port sustains one word per cycle. The RAM needs no clearing after reset. The
// user must write configuration only while no word is in flight; not enforced.
module chroma_bilinear_mc
	import cbmc_pkg::*;
#(
	parameter int MAX_WIDTH  = 8,
	parameter int MAX_HEIGHT = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // src_pixel [7:0], dst_pixel [15:8]
	input  logic                  s_tuser,   // block_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // out_pixel [7:0]
	output logic                  m_tlast
);

	localparam int DEPTH = MAX_WIDTH + 1;
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);

	logic [FRAC_W-1:0] frac_x_q, frac_y_q;
	logic [BW_W-1:0]   width_q;
	logic [BH_W-1:0]   height_q;
	logic              avg_q;

	logic [CW-1:0]     col_q, col, pend_addr_q, waddr;
	logic [RW-1:0]     row_q, row;
	logic [CW-1:0]     eff_w;
	logic [RW-1:0]     eff_h;
	logic              pend_q;
	logic [PIX_W-1:0]  left_q, tr_q, rdata;
	logic              acc, we, row_end, emit, last;

	logic              valid_s1, emit_s1, last_s1, adv1;
	logic [PIX_W-1:0]  src_s1, dst_s1, left_s1;
	logic              flt_ready;
	cbmc_taps_t        taps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_x_q <= '0;
			frac_y_q <= '0;
			width_q  <= BLOCK_WIDTH_RST;
			height_q <= BLOCK_HEIGHT_RST;
			avg_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAC_X:       frac_x_q <= cfg_wdata[FRAC_W-1:0];
				REG_FRAC_Y:       frac_y_q <= cfg_wdata[FRAC_W-1:0];
				REG_BLOCK_WIDTH:  width_q  <= cfg_wdata[BW_W-1:0];
				REG_BLOCK_HEIGHT: height_q <= cfg_wdata[BH_W-1:0];
				REG_AVERAGE_MODE: avg_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = CW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = RW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_h = RW'(MAX_HEIGHT);
		end else begin
			eff_h = RW'(height_q);
		end
	end

	assign acc     = s_tvalid && s_tready;
	assign col     = s_tuser ? '0 : col_q;
	assign row     = s_tuser ? '0 : row_q;
	assign row_end = col >= eff_w;
	assign emit    = (row != '0) && (col != '0);
	assign last    = (row >= eff_h) && row_end;
	assign we      = acc && ((col != '0) || pend_q);
	assign waddr   = (col != '0) ? col - CW'(1) : pend_addr_q;

	cbmc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_line (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (left_q),
		.re    (acc),
		.raddr (col),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= 1'b0;
			left_q <= '0;
		end else if (acc) begin
			col_q  <= row_end ? '0 : col + CW'(1);
			row_q  <= row_end ? ((row >= eff_h) ? '0 : row + RW'(1)) : row;
			pend_q <= row_end;
			left_q <= s_tdata[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pend_addr_q <= col;
			src_s1      <= s_tdata[7:0];
			dst_s1      <= s_tdata[15:8];
			left_s1     <= left_q;
			emit_s1     <= emit;
			last_s1     <= last;
		end
		if (adv1) begin
			tr_q <= rdata;
		end
	end

	assign adv1     = valid_s1 && (!emit_s1 || flt_ready);
	assign s_tready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	assign taps = '{tl: tr_q, tr: rdata, bl: left_s1, br: src_s1, dst: dst_s1,
	                last: last_s1};

	cbmc_filter u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.frac_x       (frac_x_q),
		.frac_y       (frac_y_q),
		.average_mode (avg_q),
		.in_valid     (valid_s1 && emit_s1),
		.in_ready     (flt_ready),
		.taps         (taps),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_pixel    (m_tdata),
		.out_last     (m_tlast)
	);

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) <= MAX_WIDTH)
		else $error("column counter past line buffer");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) <= MAX_HEIGHT)
		else $error("row counter past block");

	a_pend_col: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> col_q == '0)
		else $error("deferred write pending mid-row");

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> waddr != col)
		else $error("line buffer read and write hit one entry");

endmodule
